### rtl/spq_pkg.sv
package spq_pkg;

	// Default number of cells, one stored job in each.
	localparam int unsigned DEPTH_DEF = 16;

	// Width of the occupancy field in a result.
	localparam int unsigned OCC_W = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// One stored job.
	typedef struct packed {
		logic [15:0] job_id;
		logic [7:0]  prio;
		logic [31:0] payload;
	} entry_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [15:0] job_id;
		logic [7:0]  priority_req;
		logic [31:0] payload;
	} in_item_t;

	typedef struct packed {
		status_t        status;
		logic [15:0]    out_job_id;
		logic [7:0]     out_priority;
		logic [31:0]    out_payload;
		logic [OCC_W-1:0] occupancy;
	} out_item_t;

	// Control shared by every cell of the chain in one cycle.
	typedef struct packed {
		logic   ins_en;
		logic   pop_en;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

### rtl/spq_cell.sv
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               left_ge,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               ge
);
	import spq_pkg::*;

	entry_t entry_q;

	// This cell keeps its job on an insert when it holds a job at least as urgent.
	assign ge    = occupied && (entry_q.prio >= ctrl.new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop_en) begin
			entry_q <= right_entry;
		end else if (ctrl.ins_en && !ge) begin
			// The first cell that does not keep its job takes the new one; the rest shift down.
			if (left_ge) begin
				entry_q <= ctrl.new_entry;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

endmodule

### rtl/stable_priority_queue_top.sv
// Bounded priority queue with first-in first-out order among equal priorities. A command
// (insert or pop) is transferred at a rising edge where start is high and busy is low; busy
// never rises, so one command can be transferred in every cycle. Each command gives exactly
// one result, shown on result with done high for the single cycle that follows the transfer;
// the receiver cannot stall it and must take it in that cycle. The queue is a chain of DEPTH
// cells kept in order with the most urgent job in cell 0: every cell compares its own
// priority with the incoming one in parallel, and the whole chain shifts by one place in the
// same cycle, so the rate is set by that single compare and shift. An insert into a full
// queue is dropped with status full, a pop from an empty queue returns status empty, and
// the job fields of a result are zero unless a pop succeeded. Occupancy reports the low
// bits of the job count after the command.
module stable_priority_queue_top #(
	parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spq_pkg::in_item_t  cmd,
	output logic               done,
	output spq_pkg::out_item_t result
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic             accept;
	logic             is_ins;
	logic             is_pop;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	cell_ctrl_t       ctrl;
	entry_t           cell_entry [DEPTH];
	logic [DEPTH-1:0] cell_ge;
	logic             done_q;
	out_item_t        result_q;
	out_item_t        result_next;

	// Every command updates the queue at the edge that transfers it, so busy stays low.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_ins = accept && (cmd.opcode == OP_INSERT);
	assign is_pop = accept && (cmd.opcode == OP_POP);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	assign ctrl.ins_en              = is_ins && !full;
	assign ctrl.pop_en              = is_pop && !empty;
	assign ctrl.new_entry.job_id    = cmd.job_id;
	assign ctrl.new_entry.prio      = cmd.priority_req;
	assign ctrl.new_entry.payload   = cmd.payload;

	// The chain of cells; cell 0 is the head. A virtual cell ahead of the head always
	// counts as more urgent, and the last cell refills from itself on a pop.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   left_ge;
		entry_t left_entry;
		entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_ge    = 1'b1;
			assign left_entry = ctrl.new_entry;
		end else begin : g_body
			assign left_ge    = cell_ge[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (count_q > CNT_W'(i)),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	always_comb begin
		count_next = count_q;
		if (ctrl.ins_en) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctrl.pop_en) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		result_next              = '0;
		result_next.status       = ST_OK;
		result_next.occupancy    = OCC_W'(count_next);
		if (is_ins && full) begin
			result_next.status = ST_FULL;
		end else if (is_pop && empty) begin
			result_next.status = ST_EMPTY;
		end else if (ctrl.pop_en) begin
			result_next.out_job_id   = cell_entry[0].job_id;
			result_next.out_priority = cell_entry[0].prio;
			result_next.out_payload  = cell_entry[0].payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	// The result word needs no reset; done qualifies it.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_next;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// The job count never passes the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH))
		else $error("job count above depth");

	// A full status is reported only while the chain stays full.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (result_q.status == ST_FULL) |-> count_q == CNT_W'(DEPTH))
		else $error("full status with free cells");

	// A pop from an empty queue reports empty and zero occupancy.
	assert property (@(posedge clk) disable iff (!arst_n)
		is_pop && empty |=> done_q && (result_q.status == ST_EMPTY)
		&& (result_q.occupancy == '0))
		else $error("empty pop not reported");

	// The two cells at the head stay in priority order.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
		else $error("head cells out of order");

	// A successful pop returns the priority of the job that sat at the head.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop_en |=> result_q.out_priority == $past(cell_entry[0].prio))
		else $error("popped priority differs from head");

endmodule
